// File: sv/dsc_pkg.sv
// Package for the DVI scanline command sequencer: configuration and descriptor types,
// control-symbol constants and the command word helpers.
// No dependencies.
package dsc_pkg;

  localparam int unsigned FrameHeight = 360;
  localparam int unsigned RowW        = 10;
  localparam int unsigned LineW       = 12;
  localparam int unsigned WordW       = 30;
  localparam int unsigned CountW      = 12;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 12;

  localparam logic [LineW-1:0]  RowMax   = LineW'(FrameHeight - 1);
  localparam logic [CountW-1:0] MaxCount = '1;

  // TMDS control symbols for lane 0 (c1, c0 = vsync/hsync pair)
  localparam logic [9:0] Ctrl00 = 10'h354;
  localparam logic [9:0] Ctrl01 = 10'h0ab;
  localparam logic [9:0] Ctrl10 = 10'h154;
  localparam logic [9:0] Ctrl11 = 10'h2ab;

  localparam logic [3:0] OpRawRepeat = 4'h1;
  localparam logic [3:0] OpTmds      = 4'h2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegHFrontPorch   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHSyncWidth    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHBackPorch    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHOutputPixels = 3'd3;
  localparam logic [CfgIdxW-1:0] RegVActiveLines  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegVFrontPorch   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegVSyncWidth    = 3'd6;
  localparam logic [CfgIdxW-1:0] RegVBackPorch    = 3'd7;

  // Word slots of one line program
  localparam logic [2:0] SlotFrontPorch = 3'd0;
  localparam logic [2:0] SlotSyncOff0   = 3'd1;
  localparam logic [2:0] SlotSyncPulse  = 3'd2;
  localparam logic [2:0] SlotSyncOn     = 3'd3;
  localparam logic [2:0] SlotBackPorch  = 3'd4;
  localparam logic [2:0] SlotSyncOff1   = 3'd5;
  localparam logic [2:0] SlotTmds       = 3'd6;
  localparam logic [2:0] SlotRowFetch   = 3'd7;

  typedef struct packed {
    logic [11:0] h_front_porch;
    logic [11:0] h_sync_width;
    logic [11:0] h_back_porch;
    logic [11:0] h_output_pixels;
    logic [10:0] v_active_lines;
    logic [7:0]  v_front_porch;
    logic [7:0]  v_sync_width;
    logic [7:0]  v_back_porch;
  } cfg_t;

  typedef struct packed {
    logic            active;
    logic            vsync;
    logic [RowW-1:0] row;
    logic [31:0]     frame;
  } line_desc_t;

  function automatic logic [WordW-1:0] raw_cmd(input logic [CountW-1:0] count);
    raw_cmd = {14'd0, OpRawRepeat, count};
  endfunction

  function automatic logic [WordW-1:0] sync_word(input logic [9:0] lane0);
    sync_word = {Ctrl00, Ctrl00, lane0};
  endfunction

endpackage

// File: sv/dsc_in_if.sv
// Line event channel of the scanline command sequencer.
// Depends on nothing.
interface dsc_in_if;
  logic valid;
  logic ready;
  logic line_done;

  modport source (output valid, output line_done, input ready);
  modport sink (input valid, input line_done, output ready);
endinterface

// File: sv/dsc_out_if.sv
// Command word channel of the scanline command sequencer.
// Depends on nothing.
interface dsc_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [29:0] command_word;
  logic [9:0]  row_index;
  logic [31:0] frame_number;
  logic        last_word;

  modport source (output valid, output out_kind, output command_word, output row_index,
                  output frame_number, output last_word, input ready);
  modport sink (input valid, input out_kind, input command_word, input row_index,
                input frame_number, input last_word, output ready);
endinterface

// File: sv/dvi_scanline_command_sequencer.sv
// Scanline command sequencer: each line_done transfer advances the line counter and
// emits the next line's command program (6 words for blank/vsync lines, 8 for active).
// The first word passes the descriptor register, then the output register; after that,
// one word per cycle while out_o.ready is high. A line_done=0 transfer emits nothing.
// Reset: counters clear, 720p defaults load, no words pend.
module dvi_scanline_command_sequencer
  import dsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  dsc_in_if.sink              in_i,
  dsc_out_if.source           out_o
);

  cfg_t       cfg_q;
  line_desc_t desc;
  logic       free;
  logic       advance;

  // Configuration registers; each takes the low bits of the write data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.h_front_porch   <= 12'd110;
      cfg_q.h_sync_width    <= 12'd40;
      cfg_q.h_back_porch    <= 12'd220;
      cfg_q.h_output_pixels <= 12'd1280;
      cfg_q.v_active_lines  <= 11'd720;
      cfg_q.v_front_porch   <= 8'd5;
      cfg_q.v_sync_width    <= 8'd5;
      cfg_q.v_back_porch    <= 8'd20;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegHFrontPorch:   cfg_q.h_front_porch   <= cfg_data_i;
        RegHSyncWidth:    cfg_q.h_sync_width    <= cfg_data_i;
        RegHBackPorch:    cfg_q.h_back_porch    <= cfg_data_i;
        RegHOutputPixels: cfg_q.h_output_pixels <= cfg_data_i;
        RegVActiveLines:  cfg_q.v_active_lines  <= cfg_data_i[10:0];
        RegVFrontPorch:   cfg_q.v_front_porch   <= cfg_data_i[7:0];
        RegVSyncWidth:    cfg_q.v_sync_width    <= cfg_data_i[7:0];
        RegVBackPorch:    cfg_q.v_back_porch    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Take a new event whenever the descriptor slot is empty or hands off its last word
  // this cycle; a line_done=0 transfer is dropped with no state change.
  assign in_i.ready = free;
  assign advance    = in_i.valid && free && in_i.line_done;

  dsc_line_tracker u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .advance_i (advance),
    .desc_o    (desc)
  );

  // Hold the descriptor and advance one program word per output transfer.
  dsc_word_emitter u_emitter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .load_i         (advance),
    .desc_i         (desc),
    .free_o         (free),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_kind_o     (out_o.out_kind),
    .command_word_o (out_o.command_word),
    .row_index_o    (out_o.row_index),
    .frame_number_o (out_o.frame_number),
    .last_word_o    (out_o.last_word)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> ##1 out_o.valid)
    else $error("line event produced no output word");

  a_cfg_reaches_regs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_index_i == RegHFrontPorch |=> cfg_q.h_front_porch == $past(cfg_data_i))
    else $error("configuration write lost");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.command_word))
    else $error("output word changed while stalled");
`endif

endmodule

// File: sv/dsc_line_tracker.sv
// Scanline and frame counters; classifies the upcoming line for the word emitter.
// Depends on dsc_pkg.
module dsc_line_tracker
  import dsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       advance_i,
  output line_desc_t desc_o
);

  logic [LineW-1:0] cur_q, cur_d;
  logic [31:0]      frame_q, frame_d;
  logic [LineW-1:0] total, vs_lo, vs_hi, line;
  logic [LineW:0]   cur_inc, nxt;
  logic             wrap, active;
  logic [LineW-1:0] row_full;

  always_comb begin
    total   = LineW'(cfg_i.v_active_lines) + LineW'(cfg_i.v_front_porch)
            + LineW'(cfg_i.v_sync_width) + LineW'(cfg_i.v_back_porch);
    cur_inc = {1'b0, cur_q} + 13'd1;
    wrap    = cur_inc >= {1'b0, total};
    cur_d   = wrap ? '0 : cur_inc[LineW-1:0];
    frame_d = wrap ? frame_q + 32'd1 : frame_q;

    nxt  = {1'b0, cur_d} + 13'd1;
    line = (nxt >= {1'b0, total}) ? '0 : nxt[LineW-1:0];

    active = line < LineW'(cfg_i.v_active_lines);
    vs_lo  = LineW'(cfg_i.v_active_lines) + LineW'(cfg_i.v_front_porch);
    vs_hi  = vs_lo + LineW'(cfg_i.v_sync_width);

    row_full = {1'b0, line[LineW-1:1]};
    if (row_full > RowMax) begin
      row_full = RowMax;
    end

    desc_o.active = active;
    desc_o.vsync  = !active && (line >= vs_lo) && (line < vs_hi);
    desc_o.row    = row_full[RowW-1:0];
    desc_o.frame  = frame_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      frame_q <= '0;
    end else if (advance_i) begin
      cur_q   <= cur_d;
      frame_q <= frame_d;
    end
  end

`ifndef SYNTHESIS
  a_frame_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_q == $past(frame_q)) || (frame_q == $past(frame_q) + 32'd1))
    else $error("frame count moved by more than one");

  a_wrap_clears_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && wrap |=> cur_q == '0)
    else $error("scanline not cleared on frame wrap");

  a_vsync_not_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_o.vsync |-> !desc_o.active)
    else $error("vsync flagged on an active line");
`endif

endmodule

// File: sv/dsc_word_emitter.sv
// Holds one line descriptor and walks its command program out, one word per transfer,
// through a registered output stage. Depends on dsc_pkg.
module dsc_word_emitter
  import dsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        load_i,
  input  line_desc_t  desc_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_kind_o,
  output logic [29:0] command_word_o,
  output logic [9:0]  row_index_o,
  output logic [31:0] frame_number_o,
  output logic        last_word_o
);

  line_desc_t       desc_q;
  logic             desc_valid_q, desc_valid_d;
  logic [2:0]       idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic             load_out, word_last;
  logic [CountW:0]  merged_sum;
  logic [CountW-1:0] merged;
  logic [9:0]       sync_off, sync_on;
  logic             kind_d;
  logic [WordW-1:0] word_d;
  logic [RowW-1:0]  row_d;
  logic             kind_q, last_q;
  logic [WordW-1:0] word_q;
  logic [RowW-1:0]  row_q;
  logic [31:0]      frame_q;

  always_comb begin
    load_out  = desc_valid_q && (!out_valid_q || out_ready_i);
    word_last = (idx_q == SlotRowFetch) || (idx_q == SlotSyncOff1 && !desc_q.active);
    free_o    = !desc_valid_q || (load_out && word_last);

    merged_sum = {1'b0, cfg_i.h_back_porch} + {1'b0, cfg_i.h_output_pixels};
    merged     = merged_sum[CountW] ? MaxCount : merged_sum[CountW-1:0];
    sync_off   = desc_q.vsync ? Ctrl10 : Ctrl00;
    sync_on    = desc_q.vsync ? Ctrl11 : Ctrl01;

    kind_d = 1'b0;
    row_d  = '0;
    case (idx_q)
      SlotFrontPorch: word_d = raw_cmd(cfg_i.h_front_porch);
      SlotSyncOff0:   word_d = sync_word(sync_off);
      SlotSyncPulse:  word_d = raw_cmd(cfg_i.h_sync_width);
      SlotSyncOn:     word_d = sync_word(sync_on);
      SlotBackPorch:  word_d = raw_cmd(desc_q.active ? cfg_i.h_back_porch : merged);
      SlotSyncOff1:   word_d = sync_word(sync_off);
      SlotTmds:       word_d = {14'd0, OpTmds, cfg_i.h_output_pixels};
      SlotRowFetch: begin
        word_d = '0;
        kind_d = 1'b1;
        row_d  = desc_q.row;
      end
      default:        word_d = '0;
    endcase

    idx_d        = idx_q;
    desc_valid_d = desc_valid_q;
    if (load_out) begin
      idx_d = idx_q + 3'd1;
      if (word_last) begin
        desc_valid_d = 1'b0;
      end
    end
    if (load_i) begin
      idx_d        = SlotFrontPorch;
      desc_valid_d = 1'b1;
    end

    out_valid_d = load_out || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_valid_q <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      desc_valid_q <= desc_valid_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      desc_q <= desc_i;
    end
    if (load_out) begin
      kind_q  <= kind_d;
      word_q  <= word_d;
      row_q   <= row_d;
      frame_q <= desc_q.frame;
      last_q  <= word_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = kind_q;
  assign command_word_o = word_q;
  assign row_index_o    = row_q;
  assign frame_number_o = frame_q;
  assign last_word_o    = last_q;

`ifndef SYNTHESIS
  a_blank_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_valid_q && !desc_q.active |-> idx_q <= SlotSyncOff1)
    else $error("blank line program ran past its sixth word");

  a_fetch_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_o |-> last_word_o && command_word_o == '0)
    else $error("row fetch not the clean final word");

  a_load_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> desc_valid_q && idx_q == SlotFrontPorch)
    else $error("new program did not start at its first word");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("descriptor overwritten while words remain");
`endif

endmodule

// File: bench/dvi_scanline_command_sequencer_test.sv
// Self-checking bench for the DVI scanline command sequencer: predicts each line program
// from its own copy of the timing registers and counters and checks every word transfer.
// Depends on dsc_pkg, dsc_in_if, dsc_out_if and dvi_scanline_command_sequencer.
module dvi_scanline_command_sequencer_test;
  import dsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One program word as it leaves the block
  typedef struct packed {
    logic        kind;
    logic [29:0] word;
    logic [9:0]  row;
    logic [31:0] frame;
    logic        last;
  } cmd_word_t;

  // Holds the timing registers, the line and frame counters and the words still owed.
  class line_program_checker;
    int unsigned hfp = 110, hsw = 40, hbp = 220, hpix = 1280;
    int unsigned vact = 720, vfp = 5, vsw = 5, vbp = 20;
    int unsigned line_q = 0;
    logic [31:0] frame_q = '0;
    cmd_word_t   owed_words[$];
    int errors, n_events, n_advances, n_wraps, n_vsync, n_active, n_clamped, n_words;

    function int pending();
      return owed_words.size();
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegHFrontPorch:   hfp = data;
        RegHSyncWidth:    hsw = data;
        RegHBackPorch:    hbp = data;
        RegHOutputPixels: hpix = data;
        RegVActiveLines:  vact = data[10:0];
        RegVFrontPorch:   vfp = data[7:0];
        RegVSyncWidth:    vsw = data[7:0];
        RegVBackPorch:    vbp = data[7:0];
        default: ;
      endcase
    endfunction

    function logic [29:0] repeat_word(int unsigned count);
      if (count > MaxCount) count = MaxCount;
      return {14'd0, OpRawRepeat, count[11:0]};
    endfunction

    function void add_word(logic kind, logic [29:0] word, logic [9:0] row, logic last);
      cmd_word_t w;
      w.kind = kind;
      w.word = word;
      w.row = row;
      w.frame = frame_q;
      w.last = last;
      owed_words.push_back(w);
    endfunction

    // On a line_done event, advance the line counter and queue the program for the line after it.
    function void note_line_event(logic done);
      int unsigned total, cur, nxt, vs_lo, r;
      logic active, vsync;
      logic [29:0] off_w, on_w;
      n_events++;
      if (!done) return;
      n_advances++;
      total = vact + vfp + vsw + vbp;
      cur = line_q + 1;
      if (cur >= total) begin
        cur = 0;
        frame_q++;
        n_wraps++;
      end
      line_q = cur & 12'hFFF;
      nxt = line_q + 1;
      if (nxt >= total) nxt = 0;
      active = nxt < vact;
      vs_lo = vact + vfp;
      vsync = !active && nxt >= vs_lo && nxt < vs_lo + vsw;
      off_w = {Ctrl00, Ctrl00, vsync ? Ctrl10 : Ctrl00};
      on_w = {Ctrl00, Ctrl00, vsync ? Ctrl11 : Ctrl01};
      if (vsync) n_vsync++;
      add_word(1'b0, repeat_word(hfp), '0, 1'b0);
      add_word(1'b0, off_w, '0, 1'b0);
      add_word(1'b0, repeat_word(hsw), '0, 1'b0);
      add_word(1'b0, on_w, '0, 1'b0);
      if (active) begin
        n_active++;
        add_word(1'b0, repeat_word(hbp), '0, 1'b0);
        add_word(1'b0, off_w, '0, 1'b0);
        add_word(1'b0, {14'd0, OpTmds, hpix[11:0]}, '0, 1'b0);
        r = nxt >> 1;
        if (r > FrameHeight - 1) begin
          r = FrameHeight - 1;
          n_clamped++;
        end
        add_word(1'b1, '0, r[9:0], 1'b1);
      end else begin
        add_word(1'b0, repeat_word(hbp + hpix), '0, 1'b0);
        add_word(1'b0, off_w, '0, 1'b1);
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_word(cmd_word_t got);
      cmd_word_t want;
      n_words++;
      if (owed_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing owed: %h", n_words, got));
        return;
      end
      want = owed_words.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("word %0d out_kind %b, want %b", n_words, got.kind,
                                  want.kind));
      if (got.word !== want.word)
        report_mismatch($sformatf("word %0d command_word %h, want %h", n_words, got.word,
                                  want.word));
      if (got.row !== want.row)
        report_mismatch($sformatf("word %0d row_index %0d, want %0d", n_words, got.row,
                                  want.row));
      if (got.frame !== want.frame)
        report_mismatch($sformatf("word %0d frame_number %0d, want %0d", n_words,
                                  got.frame, want.frame));
      if (got.last !== want.last)
        report_mismatch($sformatf("word %0d last_word %b, want %b", n_words, got.last,
                                  want.last));
    endtask
  endclass

  // Cycles to let pass after the last owed word before touching the registers
  localparam int SettleCycles = 8;
  // line_done values of the opening directed run, sent from the top bit down
  localparam logic [23:0] DirectedDone = 24'b0111_0011_1110_1111_1101_1111;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int   src_idle_pct;
  int   rcv_idle_pct;
  logic hold_off;

  line_program_checker sb = new();

  dsc_in_if  in_if ();
  dsc_out_if out_if ();

  dvi_scanline_command_sequencer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Receiver: drop ready at random, and hold it low for the whole of a hold-off.
  always @(posedge clk_i) begin
    out_if.ready <= !hold_off && ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Observe both channels on the same edge; the input transfer is noted first so that
  // its words are owed before any of them can be checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_line_event(in_if.line_done);
      if (out_if.valid && out_if.ready)
        sb.check_word({out_if.out_kind, out_if.command_word, out_if.row_index,
                       out_if.frame_number, out_if.last_word});
    end
  end

  // Offer one line event, idling first at random; return on the edge of its transfer.
  task automatic send_line_event(input logic done);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.line_done <= done;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Drop valid, wait for every owed word, then let the block settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_line_events(input int count, input int done_pct);
    repeat (count) send_line_event($urandom_range(0, 99) < done_pct);
    drain();
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Load all eight timing registers back to back; only called with the block idle.
  task automatic program_timing(input logic [11:0] hfp, input logic [11:0] hsw,
                                input logic [11:0] hbp, input logic [11:0] hpix,
                                input logic [11:0] vact, input logic [11:0] vfp,
                                input logic [11:0] vsw, input logic [11:0] vbp);
    write_reg(RegHFrontPorch, hfp);
    write_reg(RegHSyncWidth, hsw);
    write_reg(RegHBackPorch, hbp);
    write_reg(RegHOutputPixels, hpix);
    write_reg(RegVActiveLines, vact);
    write_reg(RegVFrontPorch, vfp);
    write_reg(RegVSyncWidth, vsw);
    write_reg(RegVBackPorch, vbp);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Starve the output for a counted stretch so the block backs up into its input.
  task automatic hold_receiver(input int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_off <= 1'b0;
  endtask

  // Stop a hung run.
  initial begin
    #2_000_000;
    $display("dvi_scanline_command_sequencer regression: fail");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.line_done = 1'b0;
    out_if.ready = 1'b0;
    hold_off = 1'b0;
    // slow sender, very slow receiver first
    src_idle_pct = 28;
    rcv_idle_pct = 85;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset timing: early active lines, with a few events that carry no line_done.
    for (int i = 23; i >= 0; i--) send_line_event(DirectedDone[i]);
    drain();

    // Every horizontal count at its top: the merged back porch count saturates. The
    // tiny frame also leaves the counter beyond the new total, so the first advance wraps.
    program_timing(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'd3, 12'd1, 12'd2, 12'd1);
    run_line_events(60, 80);

    // Swap the idling sides.
    src_idle_pct = 85;
    rcv_idle_pct = 28;

    // Zero horizontal counts; high data bits above the vertical fields must be dropped.
    program_timing(12'h000, 12'h000, 12'h000, 12'h000, 12'h802, 12'hF00, 12'hE01, 12'h000);
    run_line_events(50, 80);

    // An empty frame: every advance wraps and bumps the frame count.
    program_timing(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   12'h800, 12'h000, 12'h000, 12'h000);
    run_line_events(15, 80);

    // Small random frames; the last one runs with no idling and a long output hold-off.
    for (int k = 0; k < 3; k++) begin
      if (k == 2) begin
        src_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      program_timing(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                     12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                     12'($urandom_range(1, 12)), 12'($urandom_range(0, 4)),
                     12'($urandom_range(1, 4)), 12'($urandom_range(0, 4)));
      if (k == 2) begin
        fork
          hold_receiver(300);
        join_none
      end
      run_line_events(40, 75);
    end

    // Tallest frame: large vertical counts, a run of active lines with no wrap.
    program_timing(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   12'hFFF, 12'h0FF, 12'hFFF, 12'h0FF);
    run_line_events(40, 97);

    $display("Ran %0d line events (%0d advances, %0d frame wraps, %0d active and %0d vsync",
             sb.n_events, sb.n_advances, sb.n_wraps, sb.n_active, sb.n_vsync);
    $display("  lines, %0d clamped rows); checked %0d words, %0d mismatches.",
             sb.n_clamped, sb.n_words, sb.errors);
    if (sb.errors == 0) begin
      $display("dvi_scanline_command_sequencer regression: pass");
    end else begin
      $display("dvi_scanline_command_sequencer regression: fail");
    end
    $finish;
  end

endmodule
